### src/mts_pkg.sv
// Package for the markdown terminal styler: opcodes, character codes,
// escape segment codes, the queued command type and the segment byte tables.
// No dependencies.
package mts_pkg;

  // Opcodes of the input channel
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Line-start flag value out of reset
  localparam logic LINE_START_RESET = 1'b1;

  // Default depth of the front/back command queue
  localparam int QUEUE_DEPTH_DEF = 4;

  // Characters the classifier looks for
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_NL     = 8'h0A;

  // A command is a short list of output segments
  localparam int MAX_SEGS   = 5;
  localparam int SEG_IDX_W  = 3;
  localparam int BYTE_IDX_W = 3;

  typedef enum logic [3:0] {
    SEG_RESET,     // ESC[0m
    SEG_CYAN,      // ESC[36m
    SEG_MAGENTA,   // ESC[35m
    SEG_BOLD_ON,   // ESC[1m
    SEG_BOLD_OFF,  // ESC[22m
    SEG_YELLOW,    // ESC[33m
    SEG_HEAD,      // ESC[1;96m
    SEG_HASH3,     // "### "
    SEG_HASH2,     // "## "
    SEG_HASH1,     // "# "
    SEG_BULLET,    // UTF-8 bullet and a space
    SEG_CHAR       // the command's own byte
  } seg_t;

  typedef struct packed {
    seg_t [MAX_SEGS-1:0]  segs;
    logic [SEG_IDX_W-1:0] nseg;
    logic [7:0]           ch;
    logic                 last;
  } cmd_t;

  typedef struct packed {
    logic code_blk;
    logic math_blk;
    logic math_inl;
    logic bold;
    logic inl_code;
    logic line_start;
  } mode_t;

  // Index of the final byte of a segment
  function automatic logic [BYTE_IDX_W-1:0] seg_last_idx(input seg_t s);
    logic [BYTE_IDX_W-1:0] r;
    unique case (s)
      SEG_RESET:    r = 3'd3;
      SEG_CYAN:     r = 3'd4;
      SEG_MAGENTA:  r = 3'd4;
      SEG_BOLD_ON:  r = 3'd3;
      SEG_BOLD_OFF: r = 3'd4;
      SEG_YELLOW:   r = 3'd4;
      SEG_HEAD:     r = 3'd6;
      SEG_HASH3:    r = 3'd3;
      SEG_HASH2:    r = 3'd2;
      SEG_HASH1:    r = 3'd1;
      SEG_BULLET:   r = 3'd3;
      SEG_CHAR:     r = 3'd0;
      default:      r = 3'd0;
    endcase
    return r;
  endfunction

  // Byte idx of a segment
  function automatic logic [7:0] seg_byte(input seg_t s, input logic [BYTE_IDX_W-1:0] idx,
                                          input logic [7:0] ch);
    logic [7:0] r;
    r = 8'h00;
    unique case (s)
      SEG_RESET: begin
        unique case (idx)
          3'd0:    r = 8'h1B;
          3'd1:    r = 8'h5B;
          3'd2:    r = 8'h30;
          default: r = 8'h6D;
        endcase
      end
      SEG_CYAN, SEG_MAGENTA, SEG_YELLOW: begin
        unique case (idx)
          3'd0:    r = 8'h1B;
          3'd1:    r = 8'h5B;
          3'd2:    r = 8'h33;
          3'd3:    r = (s == SEG_CYAN) ? 8'h36 : ((s == SEG_MAGENTA) ? 8'h35 : 8'h33);
          default: r = 8'h6D;
        endcase
      end
      SEG_BOLD_ON: begin
        unique case (idx)
          3'd0:    r = 8'h1B;
          3'd1:    r = 8'h5B;
          3'd2:    r = 8'h31;
          default: r = 8'h6D;
        endcase
      end
      SEG_BOLD_OFF: begin
        unique case (idx)
          3'd0:    r = 8'h1B;
          3'd1:    r = 8'h5B;
          3'd2:    r = 8'h32;
          3'd3:    r = 8'h32;
          default: r = 8'h6D;
        endcase
      end
      SEG_HEAD: begin
        unique case (idx)
          3'd0:    r = 8'h1B;
          3'd1:    r = 8'h5B;
          3'd2:    r = 8'h31;
          3'd3:    r = 8'h3B;
          3'd4:    r = 8'h39;
          3'd5:    r = 8'h36;
          default: r = 8'h6D;
        endcase
      end
      SEG_HASH3, SEG_HASH2, SEG_HASH1: begin
        r = (idx == seg_last_idx(s)) ? CH_SPACE : CH_HASH;
      end
      SEG_BULLET: begin
        unique case (idx)
          3'd0:    r = 8'hE2;
          3'd1:    r = 8'h80;
          3'd2:    r = 8'hA2;
          default: r = CH_SPACE;
        endcase
      end
      SEG_CHAR: r = ch;
      default:  r = ch;
    endcase
    return r;
  endfunction

endpackage

### src/mts_ifs.sv
// Valid/ready channel interfaces for the markdown terminal styler:
// text input, styled byte output and the line-start configuration write.
// No dependencies.
interface mts_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] char_in;
  modport source (output valid, output opcode, output char_in, input ready);
  modport sink   (input valid, input opcode, input char_in, output ready);
endinterface

interface mts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface mts_cfg_if;
  logic valid;
  logic ready;
  logic line_start_on_reset;
  modport source (output valid, output line_start_on_reset, input ready);
  modport sink   (input valid, input line_start_on_reset, output ready);
endinterface

### src/mts_front.sv
// Front end: accepts input beats and config writes, keeps the byte window and
// mode flags, classifies one token per cycle unless the queue is full and pushes commands to the queue.
// Depends on mts_pkg and mts_ifs.
module mts_front (
  input  logic          clk,
  input  logic          rst_n,
  mts_in_if.sink        in_ch,
  mts_cfg_if.sink       cfg_ch,
  input  logic          q_full,
  output logic          q_push,
  output mts_pkg::cmd_t q_cmd
);
  import mts_pkg::*;

  logic [2:0][7:0] held_r, held_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  mode_t           mode_r, mode_nxt;
  logic            draining_r, draining_nxt;

  logic [3:0][7:0] win;
  logic [2:0]      wlen;
  logic [2:0]      tok_n;
  cmd_t            tok_cmd;
  mode_t           tok_mode;
  logic [2:0][7:0] tok_held;
  logic [2:0]      tok_left;
  logic            in_fire;
  logic            cfg_fire;

  assign in_ch.ready  = !draining_r && !q_full;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  // Window: held bytes, then the new byte on a push
  always_comb begin
    win[0] = held_r[0];
    win[1] = held_r[1];
    win[2] = held_r[2];
    win[3] = draining_r ? 8'h00 : in_ch.char_in;
    wlen   = draining_r ? {1'b0, cnt_r} : 3'd4;
  end

  // Token classifier, first match wins
  always_comb begin
    logic [2:0] k;
    k                = 3'd1;
    tok_n            = 3'd1;
    tok_mode         = mode_r;
    tok_mode.line_start = 1'b0;
    tok_cmd.segs     = '{default: SEG_CHAR};
    tok_cmd.nseg     = 3'd1;
    tok_cmd.ch       = win[0];
    tok_cmd.last     = !draining_r;
    priority if (wlen >= 3'd3 && win[0] == CH_BTICK && win[1] == CH_BTICK
                 && win[2] == CH_BTICK) begin
      tok_mode.code_blk = !mode_r.code_blk;
      tok_cmd.segs[0]   = tok_mode.code_blk ? SEG_CYAN : SEG_RESET;
      tok_n             = 3'd3;
    end else if (wlen >= 3'd2 && ((win[0] == CH_DOLLAR && win[1] == CH_DOLLAR)
                 || (win[0] == CH_BSLASH && (win[1] == CH_LBRACK || win[1] == CH_RBRACK)))) begin
      tok_mode.math_blk = !mode_r.math_blk;
      tok_cmd.segs[0]   = tok_mode.math_blk ? SEG_MAGENTA : SEG_RESET;
      tok_n             = 3'd2;
    end else if (wlen >= 3'd2 && win[0] == CH_BSLASH
                 && (win[1] == CH_LPAREN || win[1] == CH_RPAREN)) begin
      tok_mode.math_inl = !mode_r.math_inl;
      tok_cmd.segs[0]   = tok_mode.math_inl ? SEG_MAGENTA : SEG_RESET;
      tok_n             = 3'd2;
    end else if (wlen >= 3'd2 && win[0] == CH_STAR && win[1] == CH_STAR) begin
      tok_mode.bold   = !mode_r.bold;
      tok_cmd.segs[0] = tok_mode.bold ? SEG_BOLD_ON : SEG_BOLD_OFF;
      tok_n           = 3'd2;
    end else if (mode_r.line_start && wlen >= 3'd4 && win[0] == CH_HASH
                 && win[1] == CH_HASH && win[2] == CH_HASH && win[3] == CH_SPACE) begin
      tok_cmd.segs[0] = SEG_HEAD;
      tok_cmd.segs[1] = SEG_HASH3;
      tok_cmd.nseg    = 3'd2;
      tok_n           = 3'd4;
    end else if (mode_r.line_start && wlen >= 3'd3 && win[0] == CH_HASH
                 && win[1] == CH_HASH && win[2] == CH_SPACE) begin
      tok_cmd.segs[0] = SEG_HEAD;
      tok_cmd.segs[1] = SEG_HASH2;
      tok_cmd.nseg    = 3'd2;
      tok_n           = 3'd3;
    end else if (mode_r.line_start && wlen >= 3'd2 && win[0] == CH_HASH
                 && win[1] == CH_SPACE) begin
      tok_cmd.segs[0] = SEG_HEAD;
      tok_cmd.segs[1] = SEG_HASH1;
      tok_cmd.nseg    = 3'd2;
      tok_n           = 3'd2;
    end else if (mode_r.line_start && wlen >= 3'd2 && win[1] == CH_SPACE
                 && (win[0] == CH_DASH || win[0] == CH_STAR)) begin
      tok_cmd.segs[0] = SEG_YELLOW;
      tok_cmd.segs[1] = SEG_BULLET;
      tok_cmd.segs[2] = SEG_RESET;
      tok_cmd.nseg    = 3'd3;
      tok_n           = 3'd2;
    end else if (wlen >= 3'd1 && win[0] == CH_BTICK) begin
      tok_mode.inl_code = !mode_r.inl_code;
      tok_cmd.segs[0]   = tok_mode.inl_code ? SEG_CYAN : SEG_RESET;
    end else if (wlen >= 3'd1 && win[0] == CH_DOLLAR) begin
      tok_mode.math_inl = !mode_r.math_inl;
      tok_cmd.segs[0]   = tok_mode.math_inl ? SEG_MAGENTA : SEG_RESET;
    end else if (win[0] == CH_NL) begin
      // reset, then the code-block, math-block and bold styles still open, then the newline itself
      tok_mode.line_start = 1'b1;
      tok_cmd.segs[0]     = SEG_RESET;
      if (mode_r.code_blk) begin
        tok_cmd.segs[k] = SEG_CYAN;
        k               = k + 3'd1;
      end
      if (mode_r.math_blk) begin
        tok_cmd.segs[k] = SEG_MAGENTA;
        k               = k + 3'd1;
      end
      if (mode_r.bold) begin
        tok_cmd.segs[k] = SEG_BOLD_ON;
        k               = k + 3'd1;
      end
      tok_cmd.segs[k] = SEG_CHAR;
      tok_cmd.nseg    = k + 3'd1;
    end else begin
      tok_cmd.segs[0] = SEG_CHAR;
    end
  end

  // Remaining window after the token is taken
  always_comb begin
    logic [2:0] idx;
    idx      = 3'd0;
    tok_left = wlen - tok_n;
    for (int i = 0; i < 3; i++) begin
      idx         = 3'(i) + tok_n;
      tok_held[i] = (idx < wlen) ? win[idx[1:0]] : 8'h00;
    end
  end

  // Sequencing of pushes, drains and config writes
  always_comb begin
    held_nxt     = held_r;
    cnt_nxt      = cnt_r;
    mode_nxt     = mode_r;
    draining_nxt = draining_r;
    q_push       = 1'b0;
    q_cmd        = tok_cmd;
    if (draining_r) begin
      if (!q_full) begin
        q_push = 1'b1;
        if (cnt_r != 2'd0) begin
          held_nxt = tok_held;
          cnt_nxt  = tok_left[1:0];
          mode_nxt = tok_mode;
        end else begin
          q_cmd.segs   = '{default: SEG_RESET};
          q_cmd.nseg   = 3'd1;
          q_cmd.last   = 1'b1;
          draining_nxt = 1'b0;
        end
      end
    end else if (in_fire) begin
      if (in_ch.opcode == OP_DRAIN) begin
        draining_nxt = 1'b1;
      end else if (cnt_r == 2'd3) begin
        q_push   = 1'b1;
        held_nxt = tok_held;
        cnt_nxt  = tok_left[1:0];
        mode_nxt = tok_mode;
      end else begin
        held_nxt[cnt_r] = in_ch.char_in;
        cnt_nxt         = cnt_r + 2'd1;
      end
    end
    if (cfg_fire) begin
      mode_nxt.line_start = cfg_ch.line_start_on_reset;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= '0;
      cnt_r      <= 2'd0;
      mode_r     <= '{code_blk: 1'b0, math_blk: 1'b0, math_inl: 1'b0, bold: 1'b0,
                      inl_code: 1'b0, line_start: LINE_START_RESET};
      draining_r <= 1'b0;
    end else begin
      held_r     <= held_nxt;
      cnt_r      <= cnt_nxt;
      mode_r     <= mode_nxt;
      draining_r <= draining_nxt;
    end
  end

endmodule

### src/mts_queue.sv
// Command queue between the front and back ends of the styler.
// Small register array with wrap-around pointers and an occupancy count.
// Depends on mts_pkg.
module mts_queue #(
  parameter int DEPTH = mts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mts_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          head_valid,
  output mts_pkg::cmd_t head_cmd,
  input  logic          pop
);
  import mts_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### src/mts_back.sv
// Back end: walks the segments of the head command one byte per cycle while the
// output is not stalled, and drives the registered output channel.
// Depends on mts_pkg and mts_ifs.
module mts_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  mts_pkg::cmd_t q_cmd,
  output logic          q_pop,
  mts_out_if.source     out_ch
);
  import mts_pkg::*;

  logic [SEG_IDX_W-1:0]  p_r, p_nxt;
  logic [BYTE_IDX_W-1:0] b_r, b_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_byte_r, out_byte_nxt;
  logic                  out_last_r, out_last_nxt;

  seg_t cur_seg;
  logic seg_done;
  logic cmd_done;
  logic advance;

  assign cur_seg  = q_cmd.segs[p_r];
  assign seg_done = (b_r == seg_last_idx(cur_seg));
  assign cmd_done = seg_done && (p_r == q_cmd.nseg - 3'd1);
  assign advance  = q_valid && (!out_valid_r || out_ch.ready);
  assign q_pop    = advance && cmd_done;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = out_last_r;

  // Byte sequencer and output register load
  always_comb begin
    p_nxt         = p_r;
    b_nxt         = b_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = seg_byte(cur_seg, b_r, q_cmd.ch);
      out_last_nxt  = q_cmd.last && cmd_done;
      if (cmd_done) begin
        p_nxt = '0;
        b_nxt = '0;
      end else if (seg_done) begin
        p_nxt = p_r + 3'd1;
        b_nxt = '0;
      end else begin
        b_nxt = b_r + 3'd1;
      end
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r         <= '0;
      b_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      p_r         <= p_nxt;
      b_r         <= b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

### src/markdown_to_terminal_styler_top.sv
// A byte that fills the four-byte window goes as a command through the queue and output register.
// Throughput: one output byte per cycle from the back end while out_ch is not stalled; plain text
// runs at one beat per cycle until the queue is full, as an N-byte escape holds the queue head until
// all are sent. A drain pushes each held token, then a closing reset; no input meanwhile.
// Reset (rst_n low, synchronous) empties the window and queue, clears all styles, sets line start.
// Top level of the markdown terminal styler; depends on mts_pkg, mts_ifs and the mts_* modules.
module markdown_to_terminal_styler_top #(
  parameter int QUEUE_DEPTH = mts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mts_in_if.sink    in_ch,
  mts_out_if.source out_ch,
  mts_cfg_if.sink   cfg_ch
);
  import mts_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_valid;
  cmd_t q_head_cmd;
  logic q_pop;

  // Classify and sequence tokens
  mts_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_push_cmd)
  );

  // Decoupling queue
  mts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop)
  );

  // Expand commands into bytes
  mts_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_head_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

### src/mts_checker.sv
// Port-level checks for the markdown terminal styler, bound to the top level.
// Depends on mts_pkg and markdown_to_terminal_styler_top.
module mts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_opcode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);
  import mts_pkg::*;

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output beat changed while stalled");

  // Accepting a drain busies the front end
  a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == OP_DRAIN |=> !in_ready)
    else $error("input taken right after a drain beat");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind markdown_to_terminal_styler_top mts_checker u_mts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_opcode (in_ch.opcode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.last_of_run)
);
